[rtl/assert_macros.svh]
// assertion helpers for the integer alu
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("%m: forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

[rtl/ialu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ialu_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int OP_W       = 3;
  localparam int CNT_W      = $clog2(DATA_WIDTH + 1);

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_ADD = 3'd0,
    OP_MUL = 3'd1,
    OP_SUB = 3'd2,
    OP_POW = 3'd3,
    OP_DIV = 3'd4,
    OP_REM = 3'd5,
    OP_XOR = 3'd6
  } op_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic done;
  } sts_t;

endpackage

`default_nettype wire

[rtl/ialu_if.sv]
`timescale 1ns / 1ps
`default_nettype none

// operand item channel
interface ialu_in_if import ialu_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic [OP_W-1:0]              operation;
  logic signed [DATA_WIDTH-1:0] left_operand;
  logic signed [DATA_WIDTH-1:0] right_operand;

  modport source (output valid, output operation, output left_operand,
                  output right_operand, input ready);
  modport sink   (input valid, input operation, input left_operand,
                  input right_operand, output ready);
endinterface

// result item channel
interface ialu_out_if import ialu_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] result_value;
  logic                         divide_by_zero;

  modport source (output valid, output result_value, output divide_by_zero,
                  input ready);
  modport sink   (input valid, input result_value, input divide_by_zero,
                  output ready);
endinterface

`default_nettype wire

[rtl/integer_alu_with_power_divide.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// 32-bit integer alu: add, multiply, subtract, power, divide, remainder and
// xor on signed operands, one result item per operand item. Power uses a
// square-and-multiply loop that retires one exponent bit per cycle, and
// divide and remainder use a restoring divider that produces one quotient bit
// per cycle. One item is in work at a time; the next is taken in the cycle
// after the previous result enters the output register, even while that
// result still waits to be taken. Divide or remainder by zero returns 0 with
// divide_by_zero set; power with exponent 0 gives 1, with a negative exponent
// it gives the base.
module integer_alu_with_power_divide import ialu_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  ialu_in_if.sink      in_i,
  ialu_out_if.source   out_o
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;
  logic out_valid;

  // sequencer
  ialu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // arithmetic
  ialu_dp u_dp (
    .clk_i            (clk_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .operation_i      (in_i.operation),
    .left_operand_i   (in_i.left_operand),
    .right_operand_i  (in_i.right_operand),
    .result_value_o   (out_o.result_value),
    .divide_by_zero_o (out_o.divide_by_zero)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

  // one item in work at a time
  `ASSERT_CLK(a_busy_after_accept, clk_i, rst_ni, (in_i.valid && in_i.ready) |=> !in_i.ready)
  // a new result appears only from the finish step
  `ASSERT_CLK(a_valid_from_finish, clk_i, rst_ni, $rose(out_o.valid) |-> $past(cmd.finish))
  // a zero divisor always gives a zero result
  `ASSERT_NEVER(a_dz_zero_result, clk_i, rst_ni, out_o.valid && out_o.divide_by_zero && (out_o.result_value != '0))

endmodule

`default_nettype wire

[rtl/ialu_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module ialu_ctrl import ialu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_FIN  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // output register can take a new result
  assign out_free = !out_valid_q || out_ready_i;

  // commands
  assign in_ready_o    = (state_q == ST_IDLE);
  assign cmd_o.load    = in_ready_o && in_valid_i;
  assign cmd_o.step    = (state_q == ST_RUN) && !sts_i.done;
  assign cmd_o.finish  = (state_q == ST_FIN) && out_free;
  assign out_valid_o   = out_valid_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (sts_i.done) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

[rtl/ialu_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module ialu_dp import ialu_pkg::*; (
  input  logic                  clk_i,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  input  logic [OP_W-1:0]       operation_i,
  input  logic [DATA_WIDTH-1:0] left_operand_i,
  input  logic [DATA_WIDTH-1:0] right_operand_i,
  output logic [DATA_WIDTH-1:0] result_value_o,
  output logic                  divide_by_zero_o
);

  localparam int W = DATA_WIDTH;

  op_e             op_q;
  logic            a_neg_q, b_neg_q, dz_q;
  logic [W-1:0]    acc_q, base_q, exp_q;
  logic [W-1:0]    rem_q, quo_q, dvs_q;
  logic [CNT_W-1:0] cnt_q;
  logic [W-1:0]    res_q;
  logic            res_dz_q;

  op_e             op_in;
  logic            is_div_in, b_zero;
  logic [W-1:0]    mag_a, mag_b;
  logic [2*W-1:0]  prod_acc, prod_sq;
  logic [W:0]      rem_sh;
  logic            rem_ge;
  logic [W-1:0]    fin_val;
  logic [W-1:0]    ld_acc, ld_base, ld_exp;
  logic [CNT_W-1:0] ld_cnt;

  assign op_in     = op_e'(operation_i);
  assign is_div_in = (op_in == OP_DIV) || (op_in == OP_REM);
  assign b_zero    = (right_operand_i == '0);
  assign mag_a     = left_operand_i[W-1]  ? (~left_operand_i + 1'b1)  : left_operand_i;
  assign mag_b     = right_operand_i[W-1] ? (~right_operand_i + 1'b1) : right_operand_i;

  // square-and-multiply products, low half kept
  assign prod_acc = {{W{1'b0}}, acc_q}  * {{W{1'b0}}, base_q};
  assign prod_sq  = {{W{1'b0}}, base_q} * {{W{1'b0}}, base_q};

  // restoring division trial subtract
  assign rem_sh = {rem_q, quo_q[W-1]};
  assign rem_ge = (rem_sh >= {1'b0, dvs_q});

  // iteration finished
  assign sts_o.done = ((op_q == OP_DIV) || (op_q == OP_REM)) ? (cnt_q == '0)
                                                             : (exp_q == '0);

  // start values for a new item
  always_comb begin
    ld_acc  = '0;
    ld_base = left_operand_i;
    ld_exp  = '0;
    ld_cnt  = '0;
    case (op_in)
      OP_ADD: ld_acc = left_operand_i + right_operand_i;
      OP_SUB: ld_acc = left_operand_i - right_operand_i;
      OP_XOR: ld_acc = left_operand_i ^ right_operand_i;
      OP_MUL: begin
        ld_acc  = left_operand_i;
        ld_base = right_operand_i;
        ld_exp  = W'(1);
      end
      OP_POW: begin
        if (b_zero) begin
          ld_acc = W'(1);
        end else if (right_operand_i[W-1]) begin
          ld_acc = left_operand_i;
        end else begin
          ld_acc = W'(1);
          ld_exp = right_operand_i;
        end
      end
      OP_DIV, OP_REM: begin
        if (!b_zero) ld_cnt = CNT_W'(W);
      end
      default: ld_acc = '0;
    endcase
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= op_in;
      a_neg_q <= left_operand_i[W-1];
      b_neg_q <= right_operand_i[W-1];
      dz_q    <= is_div_in && b_zero;
      exp_q   <= ld_exp;
      cnt_q   <= ld_cnt;
      acc_q   <= ld_acc;
      base_q  <= ld_base;
      rem_q   <= '0;
      quo_q   <= mag_a;
      dvs_q   <= mag_b;
    end else if (cmd_i.step) begin
      if ((op_q == OP_DIV) || (op_q == OP_REM)) begin
        rem_q <= rem_ge ? W'(rem_sh - {1'b0, dvs_q}) : rem_sh[W-1:0];
        quo_q <= {quo_q[W-2:0], rem_ge};
        cnt_q <= cnt_q - 1'b1;
      end else begin
        if (exp_q[0]) acc_q <= prod_acc[W-1:0];
        base_q <= prod_sq[W-1:0];
        exp_q  <= exp_q >> 1;
      end
    end
  end

  // sign fix-up and result select
  always_comb begin
    case (op_q)
      OP_DIV:  fin_val = dz_q ? '0 : ((a_neg_q ^ b_neg_q) ? (~quo_q + 1'b1) : quo_q);
      OP_REM:  fin_val = dz_q ? '0 : (a_neg_q ? (~rem_q + 1'b1) : rem_q);
      default: fin_val = acc_q;
    endcase
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_q    <= fin_val;
      res_dz_q <= dz_q;
    end
  end

  assign result_value_o   = res_q;
  assign divide_by_zero_o = res_dz_q;

endmodule

`default_nettype wire
